// ----- rtl/magnetometer_frame_correction_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the magnetometer frame correction block
// Shared property forms: same-cycle and next-cycle implications, sampled on
// the rising edge of clk and switched off while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef MAGNETOMETER_FRAME_CORRECTION_ASSERT_SVH
`define MAGNETOMETER_FRAME_CORRECTION_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define MFC_ASSERT_NOW(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("mfc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define MFC_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("mfc: next-cycle check failed");

`endif

// ----- rtl/mfc_pkg.sv -----
// ---------------------------------------------------------------------------
// mfc_pkg
// Types and constants shared by the magnetometer frame correction block.
// ---------------------------------------------------------------------------
package mfc_pkg;

	// Default raw channel width and the fixed width of the register fields
	localparam int RAW_BITS_DEF = 11;
	localparam int CFG_BITS     = 11;
	localparam int COEFF_BITS   = 8;
	localparam int TEMP_BITS    = 11;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 24;

	// Output field widths
	localparam int FX_BITS = 17;
	localparam int FY_BITS = 18;
	localparam int FZ_BITS = 18;
	localparam int FLAG_BITS = 3;

	// Drift scale factor and saturation limit of the drift magnitude
	localparam int DRIFT_MUL_BITS = 15;
	localparam logic [DRIFT_MUL_BITS-1:0] DRIFT_MUL = 15'h7ae1;
	localparam int DRIFT_SHIFT = 16;
	localparam int Q_BITS = 15;
	localparam logic [Q_BITS-1:0] Q_MAX = 15'h7fff;

	// Register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_CENTER_X        = 3'd0,
		REG_CENTER_Y1       = 3'd1,
		REG_CENTER_Y2       = 3'd2,
		REG_CENTER_TEMP     = 3'd3,
		REG_UNDERFLOW_LIMIT = 3'd4,
		REG_OVERFLOW_LIMIT  = 3'd5,
		REG_DRIFT_COEFFS    = 3'd6
	} reg_idx_t;

	// Channel lanes
	localparam int CH_X  = 0;
	localparam int CH_Y1 = 1;
	localparam int CH_Y2 = 2;
	localparam int N_CH  = 3;

	// Register file contents as seen by the datapath
	typedef struct packed {
		logic [CFG_BITS-1:0]          center_x;
		logic [CFG_BITS-1:0]          center_y1;
		logic [CFG_BITS-1:0]          center_y2;
		logic [CFG_BITS-1:0]          center_temp;
		logic [CFG_BITS-1:0]          underflow_limit;
		logic [CFG_BITS-1:0]          overflow_limit;
		logic signed [COEFF_BITS-1:0] coeff_x;
		logic signed [COEFF_BITS-1:0] coeff_y1;
		logic signed [COEFF_BITS-1:0] coeff_y2;
	} cfg_t;

endpackage

// ----- rtl/mfc_regs.sv -----
// ---------------------------------------------------------------------------
// mfc_regs
// Configuration register file: decodes write transfers by index and holds
// centres, limits and drift coefficients.
// ---------------------------------------------------------------------------
module mfc_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [mfc_pkg::CFG_IDX_BITS-1:0]    wr_index,
	input  logic [mfc_pkg::CFG_DATA_BITS-1:0]   wr_data,
	output mfc_pkg::cfg_t                       cfg
);
	import mfc_pkg::*;

	cfg_t cfg_q;

	// Write the addressed register; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x        <= 11'd1024;
			cfg_q.center_y1       <= 11'd1024;
			cfg_q.center_y2       <= 11'd1024;
			cfg_q.center_temp     <= 11'd1024;
			cfg_q.underflow_limit <= 11'd0;
			cfg_q.overflow_limit  <= 11'd2047;
			cfg_q.coeff_x         <= '0;
			cfg_q.coeff_y1        <= '0;
			cfg_q.coeff_y2        <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_CENTER_X:        cfg_q.center_x        <= wr_data[CFG_BITS-1:0];
				REG_CENTER_Y1:       cfg_q.center_y1       <= wr_data[CFG_BITS-1:0];
				REG_CENTER_Y2:       cfg_q.center_y2       <= wr_data[CFG_BITS-1:0];
				REG_CENTER_TEMP:     cfg_q.center_temp     <= wr_data[CFG_BITS-1:0];
				REG_UNDERFLOW_LIMIT: cfg_q.underflow_limit <= wr_data[CFG_BITS-1:0];
				REG_OVERFLOW_LIMIT:  cfg_q.overflow_limit  <= wr_data[CFG_BITS-1:0];
				REG_DRIFT_COEFFS: begin
					cfg_q.coeff_x  <= wr_data[7:0];
					cfg_q.coeff_y1 <= wr_data[15:8];
					cfg_q.coeff_y2 <= wr_data[23:16];
				end
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/magnetometer_frame_correction.sv -----
// ---------------------------------------------------------------------------
// magnetometer_frame_correction
// Unpacks an 8-byte magnetometer frame, flags channels at the limits,
// removes centre offset and temperature drift, and forms the x, y, z axes.
//
//  channel  signals                                  direction  transfer when
//  frame    frame_valid, frame_stall, byte0..byte7   in         valid & !stall
//  result   res_valid, res_stall, busy_res, field_*  out        valid & !stall
//           range_flags, temperature
//  config   cfg_valid, cfg_ready, cfg_index, cfg_data in        valid & ready
//
// Six-stage pipeline: a frame transfer every cycle while the result side does not stall.
// The two drift multiplications (difference times coefficient, then magnitude
// times the scale factor) sit in separate stages, one per stage.
// Each stage advances when it is empty or the stage after it moves; a stall
// on the result side fills the bubbles first, then stalls the frame side.
// Reset clears the stage valid bits and loads the register defaults.
// ---------------------------------------------------------------------------
module magnetometer_frame_correction #(
	parameter int RAW_BITS = mfc_pkg::RAW_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// frame channel
	input  logic                               frame_valid,
	output logic                               frame_stall,
	input  logic [7:0]                         byte0,
	input  logic [7:0]                         byte1,
	input  logic [7:0]                         byte2,
	input  logic [7:0]                         byte3,
	input  logic [7:0]                         byte4,
	input  logic [7:0]                         byte5,
	input  logic [7:0]                         byte6,
	input  logic [7:0]                         byte7,
	// result channel
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic                               busy_res,
	output logic signed [mfc_pkg::FX_BITS-1:0] field_x,
	output logic signed [mfc_pkg::FY_BITS-1:0] field_y,
	output logic signed [mfc_pkg::FZ_BITS-1:0] field_z,
	output logic [mfc_pkg::FLAG_BITS-1:0]      range_flags,
	output logic [mfc_pkg::TEMP_BITS-1:0]      temperature,
	// configuration channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mfc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [mfc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import mfc_pkg::*;

	// Datapath widths
	localparam int CMPW = (RAW_BITS > CFG_BITS) ? RAW_BITS : CFG_BITS;
	localparam int DW   = CMPW + 1;            // temperature difference
	localparam int VW   = CMPW + 5;            // scaled, centred channel
	localparam int MW   = DW + COEFF_BITS;     // difference times coefficient
	localparam int AW   = MW - 1;              // magnitude of that product
	localparam int PW   = AW + DRIFT_MUL_BITS; // scaled magnitude
	localparam int CW   = VW + 1;              // corrected channel
	localparam int OW   = CW + 1;              // axis sums

	cfg_t cfg;

	// Configuration registers
	assign cfg_ready = 1'b1;

	mfc_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Stage flow control
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic ready_s1, ready_s2, ready_s3, ready_s4, ready_s5, ready_s6;

	assign ready_s6 = !valid_s6 || !res_stall;
	assign ready_s5 = !valid_s5 || ready_s6;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign frame_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= frame_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
			if (ready_s5) valid_s5 <= valid_s4;
			if (ready_s6) valid_s6 <= valid_s5;
		end
	end

	// ---- stage 1: unpack, limit check, centre and temperature difference
	logic [15:0]                 pair_x, pair_y1, pair_y2, pair_t;
	logic [CMPW-1:0]             raw_c  [N_CH];
	logic [CMPW-1:0]             ctr_c  [N_CH];
	logic [CMPW-1:0]             temp_c;
	logic [15:0]                 temp16;
	logic [CMPW-1:0]             lim_lo, lim_hi;
	logic signed [VW-1:0]        v_d1   [N_CH];
	logic [N_CH-1:0]             flags_d1;
	logic signed [DW-1:0]        tdiff_d1;

	assign pair_y2 = {byte0, byte1};
	assign pair_y1 = {byte2, byte3};
	assign pair_x  = {byte4, byte5};
	assign pair_t  = {byte6, byte7};

	always_comb begin
		raw_c[CH_X]  = CMPW'(pair_x[RAW_BITS-1:0]);
		raw_c[CH_Y1] = CMPW'(pair_y1[RAW_BITS-1:0]);
		raw_c[CH_Y2] = CMPW'(pair_y2[RAW_BITS-1:0]);
		ctr_c[CH_X]  = CMPW'(cfg.center_x);
		ctr_c[CH_Y1] = CMPW'(cfg.center_y1);
		ctr_c[CH_Y2] = CMPW'(cfg.center_y2);
		temp_c       = CMPW'(pair_t[RAW_BITS-1:0]);
		temp16       = 16'(pair_t[RAW_BITS-1:0]);
		lim_lo       = CMPW'(cfg.underflow_limit);
		lim_hi       = CMPW'(cfg.overflow_limit);
		for (int ch = 0; ch < N_CH; ch++) begin
			flags_d1[ch] = (raw_c[ch] <= lim_lo) || (raw_c[ch] >= lim_hi);
			v_d1[ch] = signed'({1'b0, raw_c[ch], 4'b0000})
				- signed'({1'b0, ctr_c[ch], 4'b0000});
		end
		tdiff_d1 = signed'({1'b0, temp_c}) - signed'({1'b0, CMPW'(cfg.center_temp)});
	end

	logic                  busy_s1;
	logic [TEMP_BITS-1:0]  temp_s1;
	logic [N_CH-1:0]       flags_s1;
	logic signed [VW-1:0]  v_s1 [N_CH];
	logic signed [DW-1:0]  tdiff_s1;

	always_ff @(posedge clk) begin
		if (ready_s1 && frame_valid) begin
			busy_s1  <= byte0[7];
			temp_s1  <= temp16[TEMP_BITS-1:0];
			flags_s1 <= flags_d1;
			v_s1     <= v_d1;
			tdiff_s1 <= tdiff_d1;
		end
	end

	// ---- stage 2: temperature difference times channel coefficient
	logic signed [COEFF_BITS-1:0] coeff [N_CH];
	logic signed [MW-1:0]         m_d2  [N_CH];

	always_comb begin
		coeff[CH_X]  = cfg.coeff_x;
		coeff[CH_Y1] = cfg.coeff_y1;
		coeff[CH_Y2] = cfg.coeff_y2;
		for (int ch = 0; ch < N_CH; ch++) begin
			m_d2[ch] = MW'(tdiff_s1) * MW'(coeff[ch]);
		end
	end

	logic                  busy_s2;
	logic [TEMP_BITS-1:0]  temp_s2;
	logic [N_CH-1:0]       flags_s2;
	logic signed [VW-1:0]  v_s2 [N_CH];
	logic signed [MW-1:0]  m_s2 [N_CH];

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			busy_s2  <= busy_s1;
			temp_s2  <= temp_s1;
			flags_s2 <= flags_s1;
			v_s2     <= v_s1;
			m_s2     <= m_d2;
		end
	end

	// ---- stage 3: split the product into sign and magnitude
	logic [AW-1:0] abs_d3 [N_CH];

	always_comb begin
		for (int ch = 0; ch < N_CH; ch++) begin
			abs_d3[ch] = m_s2[ch][MW-1] ? AW'(-m_s2[ch]) : AW'(m_s2[ch]);
		end
	end

	logic                  busy_s3;
	logic [TEMP_BITS-1:0]  temp_s3;
	logic [N_CH-1:0]       flags_s3;
	logic signed [VW-1:0]  v_s3   [N_CH];
	logic [AW-1:0]         abs_s3 [N_CH];
	logic [N_CH-1:0]       neg_s3;

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			busy_s3  <= busy_s2;
			temp_s3  <= temp_s2;
			flags_s3 <= flags_s2;
			v_s3     <= v_s2;
			abs_s3   <= abs_d3;
			for (int ch = 0; ch < N_CH; ch++) begin
				neg_s3[ch] <= m_s2[ch][MW-1];
			end
		end
	end

	// ---- stage 4: scale the magnitude, drop 16 fraction bits, saturate
	logic [PW-1:0]               prod_d4 [N_CH];
	logic [PW-DRIFT_SHIFT-1:0]   shr_d4  [N_CH];
	logic [Q_BITS-1:0]           q_d4    [N_CH];

	always_comb begin
		for (int ch = 0; ch < N_CH; ch++) begin
			prod_d4[ch] = PW'(abs_s3[ch]) * PW'(DRIFT_MUL);
			shr_d4[ch]  = prod_d4[ch][PW-1:DRIFT_SHIFT];
			q_d4[ch]    = (|shr_d4[ch][PW-DRIFT_SHIFT-1:Q_BITS]) ? Q_MAX
				: shr_d4[ch][Q_BITS-1:0];
		end
	end

	logic                  busy_s4;
	logic [TEMP_BITS-1:0]  temp_s4;
	logic [N_CH-1:0]       flags_s4;
	logic signed [VW-1:0]  v_s4 [N_CH];
	logic [Q_BITS-1:0]     q_s4 [N_CH];
	logic [N_CH-1:0]       neg_s4;

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			busy_s4  <= busy_s3;
			temp_s4  <= temp_s3;
			flags_s4 <= flags_s3;
			v_s4     <= v_s3;
			q_s4     <= q_d4;
			neg_s4   <= neg_s3;
		end
	end

	// ---- stage 5: remove the drift term against its sign
	logic signed [CW-1:0] c_d5 [N_CH];
	logic signed [CW-1:0] q_ext [N_CH];

	always_comb begin
		for (int ch = 0; ch < N_CH; ch++) begin
			q_ext[ch] = CW'(signed'({1'b0, q_s4[ch]}));
			c_d5[ch]  = neg_s4[ch] ? CW'(v_s4[ch]) + q_ext[ch]
				: CW'(v_s4[ch]) - q_ext[ch];
		end
	end

	logic                  busy_s5;
	logic [TEMP_BITS-1:0]  temp_s5;
	logic [N_CH-1:0]       flags_s5;
	logic signed [CW-1:0]  c_s5 [N_CH];

	always_ff @(posedge clk) begin
		if (ready_s5 && valid_s4) begin
			busy_s5  <= busy_s4;
			temp_s5  <= temp_s4;
			flags_s5 <= flags_s4;
			c_s5     <= c_d5;
		end
	end

	// ---- stage 6: form the axes; a busy frame gives all-zero fields
	logic signed [OW-1:0] ax_d6, ay_d6, az_d6;

	always_comb begin
		ax_d6 = -OW'(c_s5[CH_X]);
		ay_d6 = OW'(c_s5[CH_Y2]) - OW'(c_s5[CH_Y1]);
		az_d6 = OW'(c_s5[CH_Y2]) + OW'(c_s5[CH_Y1]);
	end

	logic                         busy_s6;
	logic signed [FX_BITS-1:0]    fx_s6;
	logic signed [FY_BITS-1:0]    fy_s6;
	logic signed [FZ_BITS-1:0]    fz_s6;
	logic [FLAG_BITS-1:0]         flags_s6;
	logic [TEMP_BITS-1:0]         temp_s6;

	always_ff @(posedge clk) begin
		if (ready_s6 && valid_s5) begin
			busy_s6 <= busy_s5;
			if (busy_s5) begin
				fx_s6    <= '0;
				fy_s6    <= '0;
				fz_s6    <= '0;
				flags_s6 <= '0;
				temp_s6  <= '0;
			end else begin
				fx_s6    <= ax_d6[FX_BITS-1:0];
				fy_s6    <= ay_d6[FY_BITS-1:0];
				fz_s6    <= az_d6[FZ_BITS-1:0];
				flags_s6 <= FLAG_BITS'(flags_s5);
				temp_s6  <= temp_s5;
			end
		end
	end

	assign res_valid   = valid_s6;
	assign busy_res    = busy_s6;
	assign field_x     = fx_s6;
	assign field_y     = fy_s6;
	assign field_z     = fz_s6;
	assign range_flags = flags_s6;
	assign temperature = temp_s6;

endmodule

// ----- rtl/mfc_checker.sv -----
// ---------------------------------------------------------------------------
// mfc_checker
// Port-level checks on the magnetometer frame correction block, bound to
// the top level.
// ---------------------------------------------------------------------------
`include "magnetometer_frame_correction_assert.svh"

module mfc_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               frame_stall,
	input  logic                               res_valid,
	input  logic                               res_stall,
	input  logic                               busy_res,
	input  logic signed [mfc_pkg::FX_BITS-1:0] field_x,
	input  logic signed [mfc_pkg::FY_BITS-1:0] field_y,
	input  logic signed [mfc_pkg::FZ_BITS-1:0] field_z,
	input  logic [mfc_pkg::FLAG_BITS-1:0]      range_flags,
	input  logic [mfc_pkg::TEMP_BITS-1:0]      temperature
);
	import mfc_pkg::*;

	// A busy frame carries no measurement
	`MFC_ASSERT_NOW(a_busy_zero, res_valid && busy_res, field_x == 0 && field_y == 0 && field_z == 0 && range_flags == 0 && temperature == 0)

	// Frame side stalls only behind a held result with the pipeline full
	`MFC_ASSERT_NOW(a_stall_cause, frame_stall, res_valid && res_stall)

	// A held result stays offered
	`MFC_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid)

	// A held result keeps its field values and busy flag
	`MFC_ASSERT_NEXT(a_res_stable, res_valid && res_stall, $stable(field_x) && $stable(field_y) && $stable(field_z) && $stable(busy_res))

endmodule

bind magnetometer_frame_correction mfc_checker u_mfc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.frame_stall (frame_stall),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.busy_res    (busy_res),
	.field_x     (field_x),
	.field_y     (field_y),
	.field_z     (field_z),
	.range_flags (range_flags),
	.temperature (temperature)
);
